@@ sv/pgct_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers for the PID gain coordinate tuner.
// No dependencies.
package pgct_pkg;

  localparam int NUM_GAINS          = 3;
  localparam int COST_WIDTH_DEFAULT = 48;
  localparam int GAIN_W             = 32;
  localparam int ERR_W              = 16;
  localparam int WLEN_W             = 16;
  localparam int ADDR_W             = 5;
  localparam int DATA_W             = 32;
  // Largest error square is 2^30, so 31 bits hold it.
  localparam int SQ_W               = 31;

  localparam logic [16:0] SCALE_DOWN = 17'd58982;
  localparam logic [16:0] SCALE_UP   = 17'd72090;

  localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RESET = 16'd100;
  localparam logic signed [GAIN_W-1:0] GAIN_RESET = 32'sd0;
  localparam logic signed [GAIN_W-1:0] STEP_RESET = 32'sd6554;

  localparam logic signed [GAIN_W-1:0] GAIN_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [GAIN_W-1:0] GAIN_MIN = 32'sh8000_0000;

  // Phase 0 measures the baseline; the last phase tries the derivative gain.
  localparam logic [1:0] LAST_PHASE = 2'd3;

  typedef enum logic [2:0] {
    REG_WINDOW_LENGTH   = 3'd0,
    REG_INIT_PROP_GAIN  = 3'd1,
    REG_INIT_INTEG_GAIN = 3'd2,
    REG_INIT_DERIV_GAIN = 3'd3,
    REG_INIT_PROP_STEP  = 3'd4,
    REG_INIT_INTEG_STEP = 3'd5,
    REG_INIT_DERIV_STEP = 3'd6
  } reg_index_t;

  typedef logic signed [GAIN_W-1:0] gain_t;

  // Saturating signed 32-bit addition.
  function automatic gain_t sat_add32(input gain_t a, input gain_t b);
    logic signed [GAIN_W:0] s;
    s = {a[GAIN_W-1], a} + {b[GAIN_W-1], b};
    if (s[GAIN_W] != s[GAIN_W-1]) begin
      return s[GAIN_W] ? GAIN_MIN : GAIN_MAX;
    end
    return s[GAIN_W-1:0];
  endfunction

  // Magnitude times k/65536, rounded half away from zero, sign applied, saturated.
  function automatic gain_t scale_q16(input logic [GAIN_W-1:0] mag, input logic neg,
                                      input logic [16:0] k);
    logic [48:0] prod;
    logic [32:0] q;
    prod = 49'(mag) * 49'(k) + 49'd32768;
    q = prod[48:16];
    if (!neg) begin
      return (q > 33'h0_7FFF_FFFF) ? GAIN_MAX : gain_t'(q[31:0]);
    end
    return (q >= 33'h0_8000_0000) ? GAIN_MIN : gain_t'(~q[31:0] + 32'd1);
  endfunction

endpackage

@@ sv/pid_gain_coordinate_tuner.sv @@
`timescale 1ns / 1ps
// Top level of the PID gain coordinate tuner: APB register file, error-square stage,
// window cost tracking and per-gain step updates. Depends on pgct_pkg.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+----------------------------------------
//   input     | in_valid / in_ready        | error_sample
//   output    | out_valid / out_ready      | prop_gain, integ_gain, deriv_gain,
//             |                            | gains_changed
//   config    | psel, penable, pwrite      | paddr, pwdata, prdata (pready tied high)
//
// One transaction per cycle unless the output stalls.
// Stage one squares the error; stage two updates the cost, phase and gains in one pass.
// A stalled output register holds the whole pipeline and drops in_ready.
// Reset is synchronous and loads the register defaults; no clearing pass is needed.
module pid_gain_coordinate_tuner #(
  parameter int COST_WIDTH = pgct_pkg::COST_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [pgct_pkg::ADDR_W-1:0]           paddr,
  input  logic [pgct_pkg::DATA_W-1:0]           pwdata,
  output logic [pgct_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [pgct_pkg::ERR_W-1:0]     error_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pgct_pkg::GAIN_W-1:0]    prop_gain,
  output logic signed [pgct_pkg::GAIN_W-1:0]    integ_gain,
  output logic signed [pgct_pkg::GAIN_W-1:0]    deriv_gain,
  output logic                                  gains_changed
);

  localparam int NG = pgct_pkg::NUM_GAINS;

  // Configuration registers.
  logic [pgct_pkg::WLEN_W-1:0] window_length;
  pgct_pkg::gain_t             init_gain [NG];
  pgct_pkg::gain_t             init_step [NG];

  // Square stage.
  logic                        s1_valid;
  logic [pgct_pkg::SQ_W-1:0]   sq;
  logic signed [31:0]          err_sq;

  // Tuning state. Only phases 0 to 2 are stored; the last phase's cost is used at once.
  logic [pgct_pkg::WLEN_W-1:0] window_position;
  logic                        warmed_up;
  logic [COST_WIDTH-1:0]       running_cost;
  logic [COST_WIDTH-1:0]       phase_costs [NG];
  logic [1:0]                  tuning_phase;
  pgct_pkg::gain_t             base_gains  [NG];
  pgct_pkg::gain_t             step_sizes  [NG];
  pgct_pkg::gain_t             trial_gains [NG];
  // Scaled steps for the end-of-round update, taken from the current step_sizes.
  pgct_pkg::gain_t             step_up     [NG];
  pgct_pkg::gain_t             step_dn     [NG];

  logic                        advance;
  logic                        fire;
  logic [pgct_pkg::WLEN_W:0]   count;
  logic                        warm_next;
  logic [COST_WIDTH:0]         cost_sum;
  logic [COST_WIDTH-1:0]       cost_after;
  logic                        window_end;
  logic                        last_phase;
  logic [COST_WIDTH-1:0]       trial_costs [NG];
  logic [pgct_pkg::GAIN_W-1:0] step_mag    [NG];
  pgct_pkg::gain_t             base_plus   [NG];
  pgct_pkg::gain_t             base_next   [NG];
  pgct_pkg::gain_t             step_next   [NG];
  pgct_pkg::gain_t             trial_next  [NG];
  logic                        cfg_write;
  pgct_pkg::reg_index_t        cfg_idx;

  assign pready    = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;
  assign fire      = s1_valid && advance;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = pgct_pkg::reg_index_t'(paddr[4:2]);
  assign err_sq    = error_sample * error_sample;

  assign count      = {1'b0, window_position} + 17'd1;
  assign warm_next  = warmed_up || (count >= {2'b00, window_length[pgct_pkg::WLEN_W-1:1]});
  assign cost_sum   = {1'b0, running_cost} + (COST_WIDTH+1)'(sq);
  assign cost_after = !warm_next ? running_cost :
                      (cost_sum[COST_WIDTH] ? '1 : cost_sum[COST_WIDTH-1:0]);
  assign window_end = count >= {1'b0, window_length};
  assign last_phase = tuning_phase == pgct_pkg::LAST_PHASE;

  always_comb begin
    for (int i = 0; i < NG - 1; i++) begin
      trial_costs[i] = phase_costs[i+1];
    end
    trial_costs[NG-1] = cost_after;
    for (int i = 0; i < NG; i++) begin
      step_mag[i]  = step_sizes[i][pgct_pkg::GAIN_W-1] ? (~step_sizes[i] + 32'd1)
                                                        : step_sizes[i];
      step_up[i]   = pgct_pkg::scale_q16(step_mag[i], step_sizes[i][pgct_pkg::GAIN_W-1],
                                         pgct_pkg::SCALE_UP);
      step_dn[i]   = pgct_pkg::scale_q16(step_mag[i], 1'b0, pgct_pkg::SCALE_DOWN);
      base_plus[i] = pgct_pkg::sat_add32(base_gains[i], step_sizes[i]);
      base_next[i] = base_gains[i];
      step_next[i] = step_sizes[i];
      if (trial_costs[i] > phase_costs[0] && step_sizes[i] > 0) begin
        step_next[i] = pgct_pkg::gain_t'(~step_sizes[i] + 32'd1);
      end else if (trial_costs[i] > phase_costs[0] && step_sizes[i] < 0) begin
        step_next[i] = step_dn[i];
      end else begin
        base_next[i] = base_plus[i];
        step_next[i] = step_up[i];
      end
      if (!window_end) begin
        trial_next[i] = trial_gains[i];
      end else if (last_phase) begin
        trial_next[i] = base_next[i];
      end else if (tuning_phase == 2'(i)) begin
        trial_next[i] = base_plus[i];
      end else begin
        trial_next[i] = base_gains[i];
      end
    end
  end

  always_comb begin
    unique case (cfg_idx)
      pgct_pkg::REG_WINDOW_LENGTH:   prdata = 32'(window_length);
      pgct_pkg::REG_INIT_PROP_GAIN:  prdata = init_gain[0];
      pgct_pkg::REG_INIT_INTEG_GAIN: prdata = init_gain[1];
      pgct_pkg::REG_INIT_DERIV_GAIN: prdata = init_gain[2];
      pgct_pkg::REG_INIT_PROP_STEP:  prdata = init_step[0];
      pgct_pkg::REG_INIT_INTEG_STEP: prdata = init_step[1];
      pgct_pkg::REG_INIT_DERIV_STEP: prdata = init_step[2];
      default:                       prdata = '0;
    endcase
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      sq <= err_sq[pgct_pkg::SQ_W-1:0];
    end
    if (fire) begin
      prop_gain     <= trial_next[0];
      integ_gain    <= trial_next[1];
      deriv_gain    <= trial_next[2];
      gains_changed <= window_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
      window_length   <= pgct_pkg::WINDOW_LENGTH_RESET;
      window_position <= '0;
      warmed_up       <= 1'b0;
      running_cost    <= '0;
      tuning_phase    <= '0;
      for (int i = 0; i < NG; i++) begin
        init_gain[i]   <= pgct_pkg::GAIN_RESET;
        init_step[i]   <= pgct_pkg::STEP_RESET;
        base_gains[i]  <= pgct_pkg::GAIN_RESET;
        trial_gains[i] <= pgct_pkg::GAIN_RESET;
        step_sizes[i]  <= pgct_pkg::STEP_RESET;
        phase_costs[i] <= '0;
      end
    end else begin
      if (advance) begin
        s1_valid  <= in_valid;
        out_valid <= s1_valid;
      end
      if (fire) begin
        warmed_up <= warm_next;
        for (int i = 0; i < NG; i++) begin
          trial_gains[i] <= trial_next[i];
        end
        if (window_end) begin
          window_position <= '0;
          running_cost    <= '0;
          if (last_phase) begin
            tuning_phase <= '0;
            for (int i = 0; i < NG; i++) begin
              base_gains[i]  <= base_next[i];
              step_sizes[i]  <= step_next[i];
              phase_costs[i] <= '0;
            end
          end else begin
            tuning_phase <= tuning_phase + 2'd1;
            for (int i = 0; i < NG; i++) begin
              if (tuning_phase == 2'(i)) begin
                phase_costs[i] <= cost_after;
              end
            end
          end
        end else begin
          window_position <= count[pgct_pkg::WLEN_W-1:0];
          running_cost    <= cost_after;
        end
      end
      if (cfg_write) begin
        unique case (cfg_idx)
          pgct_pkg::REG_WINDOW_LENGTH: window_length <= pwdata[pgct_pkg::WLEN_W-1:0];
          pgct_pkg::REG_INIT_PROP_GAIN: begin
            init_gain[0] <= pwdata; base_gains[0] <= pwdata; trial_gains[0] <= pwdata;
          end
          pgct_pkg::REG_INIT_INTEG_GAIN: begin
            init_gain[1] <= pwdata; base_gains[1] <= pwdata; trial_gains[1] <= pwdata;
          end
          pgct_pkg::REG_INIT_DERIV_GAIN: begin
            init_gain[2] <= pwdata; base_gains[2] <= pwdata; trial_gains[2] <= pwdata;
          end
          pgct_pkg::REG_INIT_PROP_STEP: begin
            init_step[0] <= pwdata; step_sizes[0] <= pwdata;
          end
          pgct_pkg::REG_INIT_INTEG_STEP: begin
            init_step[1] <= pwdata; step_sizes[1] <= pwdata;
          end
          pgct_pkg::REG_INIT_DERIV_STEP: begin
            init_step[2] <= pwdata; step_sizes[2] <= pwdata;
          end
          default: ;
        endcase
      end
    end
  end

  // The last trial phase always wraps back to the baseline phase.
  a_phase_wrap: assert property (@(posedge clk) disable iff (rst)
    (fire && window_end && last_phase) |=> (tuning_phase == 2'd0))
    else $error("tuning phase did not wrap after the last trial window");

  // A window end always restarts the cost and the position.
  a_window_restart: assert property (@(posedge clk) disable iff (rst)
    (fire && window_end) |=> (running_cost == '0 && window_position == '0))
    else $error("window end did not clear cost and position");

  // A result that reports new gains was produced by a window end.
  a_changed_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && gains_changed) |-> (window_position == '0))
    else $error("gains_changed without a window restart");

  // While the output stalls, the tuning state holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && !cfg_write) |=>
      ($stable(running_cost) && $stable(tuning_phase) && $stable(window_position)))
    else $error("tuning state moved during an output stall");

endmodule
